FILE: rtl/core/lcdtb_pkg.sv
package lcdtb_pkg;

  // Display geometry
  localparam int LINE_WIDTH = 16;
  localparam int LINE_COUNT = 2;
  localparam int STORE_SIZE = LINE_WIDTH * LINE_COUNT;

  localparam int ADDR_W = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int IDX_W  = $clog2(STORE_SIZE + LINE_WIDTH);
  localparam int COL_W  = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
  localparam int ROW_W  = $clog2(LINE_COUNT + 1);

  // Request kinds
  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_CLEAR   = 2'd1;
  localparam logic [1:0] KIND_REFRESH = 2'd2;
  localparam logic [1:0] KIND_INIT    = 2'd3;

  // Control characters
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_FF = 8'h0C;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] FILL_RESET   = 8'h20;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;

  localparam logic [1:0] INIT_LAST = 2'd3;

  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h3A;  // function set
      2'd1:    b = 8'h0C;  // display on, cursor off
      2'd2:    b = 8'h01;  // clear display
      default: b = 8'h06;  // entry mode: increment
    endcase
    return b;
  endfunction

  typedef enum logic [1:0] {PTR_HOLD, PTR_ZERO, PTR_LAST_LINE, PTR_INC} ptr_op_t;
  typedef enum logic [1:0] {SEQ_HOLD, SEQ_CLR, SEQ_COL_INC, SEQ_ROW_INC} seq_op_t;
  typedef enum logic {RD_PTR, RD_PTR_NEXT_LINE} rd_sel_t;
  typedef enum logic [1:0] {WR_FILL, WR_COPY, WR_CHAR} wr_sel_t;
  typedef enum logic [1:0] {FILL_ZERO, FILL_SPACE, FILL_CFG} fill_sel_t;
  typedef enum logic [2:0] {CUR_HOLD, CUR_HOME, CUR_CR, CUR_LF, CUR_UP, CUR_ADV} cur_op_t;
  typedef enum logic [2:0] {
    EMIT_NONE, EMIT_HOME, EMIT_ROW, EMIT_DATA, EMIT_CURSOR, EMIT_INIT
  } emit_t;

  typedef struct packed {
    logic      req_load;
    ptr_op_t   ptr_op;
    seq_op_t   seq_op;
    logic      mem_rd;
    rd_sel_t   rd_sel;
    logic      mem_wr;
    wr_sel_t   wr_sel;
    fill_sel_t fill_sel;
    cur_op_t   cur_op;
    emit_t     emit;
    logic      emit_last;
    logic [1:0] init_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic       cur_past_end;
    logic       ptr_scroll_end;
    logic       ptr_end;
    logic       seq_col_end;
    logic       seq_row_end;
  } dp_stat_t;

endpackage

FILE: rtl/core/lcdtb_dpath.sv
module lcdtb_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcdtb_pkg::dp_cmd_t   cmd,
  output lcdtb_pkg::dp_stat_t  stat,
  input  logic [1:0]           in_kind,
  input  logic [7:0]           in_char_code,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  output logic                 out_strobe,
  output logic                 out_is_data,
  output logic [7:0]           out_bus_byte,
  output logic                 out_last
);

  localparam int AW = lcdtb_pkg::ADDR_W;
  localparam int IW = lcdtb_pkg::IDX_W;
  localparam int CW = lcdtb_pkg::COL_W;
  localparam int RW = lcdtb_pkg::ROW_W;

  logic [7:0] mem [lcdtb_pkg::STORE_SIZE];
  logic [7:0] rd_r;

  logic [1:0]  kind_r;
  logic [7:0]  code_r;
  logic [7:0]  fill_char_r;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] seq_col_r, seq_col_nxt;
  logic [RW-1:0] seq_row_r, seq_row_nxt;

  logic          out_strobe_r, out_strobe_nxt;
  logic          out_is_data_r, out_is_data_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;

  logic [IW-1:0] cur_idx, next_line_idx;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data, fill_val;
  logic [RW-1:0] cur_y;
  logic [7:0]    cur_byte, row_byte;

  assign cur_idx = IW'(row_r) * IW'(lcdtb_pkg::LINE_WIDTH) + IW'(col_r);
  assign next_line_idx = IW'(ptr_r) + IW'(lcdtb_pkg::LINE_WIDTH);

  // cursor row one past the end shows on the top line
  assign cur_y    = (row_r == RW'(lcdtb_pkg::LINE_COUNT)) ? '0 : row_r;
  assign cur_byte = lcdtb_pkg::CMD_SET_ADDR | 8'((8'(cur_y) << 6) + 8'(col_r));
  assign row_byte = lcdtb_pkg::CMD_SET_ADDR | 8'(8'(seq_row_r) << 6);

  always_comb begin
    case (cmd.fill_sel)
      lcdtb_pkg::FILL_ZERO:  fill_val = 8'h00;
      lcdtb_pkg::FILL_SPACE: fill_val = lcdtb_pkg::CHAR_SPACE;
      default:               fill_val = fill_char_r;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      lcdtb_pkg::WR_COPY: begin
        wr_addr = ptr_r;
        wr_data = rd_r;
      end
      lcdtb_pkg::WR_CHAR: begin
        wr_addr = cur_idx[AW-1:0];
        wr_data = code_r;
      end
      default: begin
        wr_addr = ptr_r;
        wr_data = fill_val;
      end
    endcase
  end

  assign rd_addr = (cmd.rd_sel == lcdtb_pkg::RD_PTR_NEXT_LINE) ? next_line_idx[AW-1:0] : ptr_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_comb begin
    case (cmd.ptr_op)
      lcdtb_pkg::PTR_ZERO:      ptr_nxt = '0;
      lcdtb_pkg::PTR_LAST_LINE: ptr_nxt = AW'(lcdtb_pkg::STORE_SIZE - lcdtb_pkg::LINE_WIDTH);
      lcdtb_pkg::PTR_INC:       ptr_nxt = ptr_r + AW'(1);
      default:                  ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    seq_col_nxt = seq_col_r;
    seq_row_nxt = seq_row_r;
    case (cmd.seq_op)
      lcdtb_pkg::SEQ_CLR: begin
        seq_col_nxt = '0;
        seq_row_nxt = '0;
      end
      lcdtb_pkg::SEQ_COL_INC: seq_col_nxt = seq_col_r + CW'(1);
      lcdtb_pkg::SEQ_ROW_INC: begin
        seq_col_nxt = '0;
        seq_row_nxt = seq_row_r + RW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    case (cmd.cur_op)
      lcdtb_pkg::CUR_HOME: begin
        col_nxt = '0;
        row_nxt = '0;
      end
      lcdtb_pkg::CUR_CR: col_nxt = '0;
      lcdtb_pkg::CUR_LF: row_nxt = row_r + RW'(1);
      lcdtb_pkg::CUR_UP: row_nxt = row_r - RW'(1);
      lcdtb_pkg::CUR_ADV: begin
        if (col_r == CW'(lcdtb_pkg::LINE_WIDTH - 1)) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_strobe_nxt  = 1'b1;
    out_is_data_nxt = 1'b0;
    out_last_nxt    = cmd.emit_last;
    case (cmd.emit)
      lcdtb_pkg::EMIT_HOME:   out_byte_nxt = lcdtb_pkg::CMD_HOME;
      lcdtb_pkg::EMIT_ROW:    out_byte_nxt = row_byte;
      lcdtb_pkg::EMIT_DATA: begin
        out_byte_nxt    = rd_r;
        out_is_data_nxt = 1'b1;
      end
      lcdtb_pkg::EMIT_CURSOR: out_byte_nxt = cur_byte;
      lcdtb_pkg::EMIT_INIT:   out_byte_nxt = lcdtb_pkg::init_cmd(cmd.init_idx);
      default: begin
        out_byte_nxt   = 8'h00;
        out_strobe_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      col_r        <= '0;
      row_r        <= '0;
      seq_col_r    <= '0;
      seq_row_r    <= '0;
      fill_char_r  <= lcdtb_pkg::FILL_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      ptr_r        <= ptr_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      seq_col_r    <= seq_col_nxt;
      seq_row_r    <= seq_row_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr_en) begin
        fill_char_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      kind_r <= in_kind;
      code_r <= in_char_code;
    end
    out_is_data_r <= out_is_data_nxt;
    out_byte_r    <= out_byte_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign stat.kind           = kind_r;
  assign stat.code           = code_r;
  assign stat.cur_past_end   = (row_r >= RW'(lcdtb_pkg::LINE_COUNT));
  assign stat.ptr_scroll_end =
    (ptr_r == AW'(lcdtb_pkg::STORE_SIZE - lcdtb_pkg::LINE_WIDTH - 1));
  assign stat.ptr_end        = (ptr_r == AW'(lcdtb_pkg::STORE_SIZE - 1));
  assign stat.seq_col_end    = (seq_col_r == CW'(lcdtb_pkg::LINE_WIDTH - 1));
  assign stat.seq_row_end    = (seq_row_r == RW'(lcdtb_pkg::LINE_COUNT - 1));

  assign out_strobe   = out_strobe_r;
  assign out_is_data  = out_is_data_r;
  assign out_bus_byte = out_byte_r;
  assign out_last     = out_last_r;

  // the final bus write of a request is never followed directly by another
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_last_r |=> !out_strobe_r)
    else $error("bus write right after final write");

  // characters are only stored with the cursor inside the store
  a_char_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr && cmd.wr_sel == lcdtb_pkg::WR_CHAR |-> row_r < RW'(lcdtb_pkg::LINE_COUNT))
    else $error("character write past end of store");

  // every store read is consumed in the following cycle, never back to back
  a_read_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_rd |=> !cmd.mem_rd)
    else $error("back to back store reads");

endmodule

FILE: rtl/core/lcdtb_ctrl.sv
module lcdtb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lcdtb_pkg::dp_stat_t  stat,
  output lcdtb_pkg::dp_cmd_t   cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DISP     = 4'd1;
  localparam logic [3:0] ST_SCR_RD   = 4'd2;
  localparam logic [3:0] ST_SCR_WR   = 4'd3;
  localparam logic [3:0] ST_FILL     = 4'd4;
  localparam logic [3:0] ST_APPLY    = 4'd5;
  localparam logic [3:0] ST_REF_HOME = 4'd6;
  localparam logic [3:0] ST_REF_ROW  = 4'd7;
  localparam logic [3:0] ST_REF_RD   = 4'd8;
  localparam logic [3:0] ST_REF_DAT  = 4'd9;
  localparam logic [3:0] ST_REF_CUR  = 4'd10;
  localparam logic [3:0] ST_INIT     = 4'd11;

  logic [3:0]           state_r, state_nxt;
  lcdtb_pkg::fill_sel_t fill_sel_r, fill_sel_nxt;
  logic                 ret_apply_r, ret_apply_nxt;
  logic [1:0]           init_cnt_r, init_cnt_nxt;
  logic                 accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    fill_sel_nxt  = fill_sel_r;
    ret_apply_nxt = ret_apply_r;
    init_cnt_nxt  = init_cnt_r;

    cmd           = '0;
    cmd.ptr_op    = lcdtb_pkg::PTR_HOLD;
    cmd.seq_op    = lcdtb_pkg::SEQ_HOLD;
    cmd.rd_sel    = lcdtb_pkg::RD_PTR;
    cmd.wr_sel    = lcdtb_pkg::WR_FILL;
    cmd.fill_sel  = fill_sel_r;
    cmd.cur_op    = lcdtb_pkg::CUR_HOLD;
    cmd.emit      = lcdtb_pkg::EMIT_NONE;
    cmd.init_idx  = init_cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        cmd.req_load = start;
        if (start) begin
          state_nxt = ST_DISP;
        end
      end

      ST_DISP: begin
        unique case (stat.kind)
          lcdtb_pkg::KIND_CHAR: begin
            if (stat.cur_past_end) begin
              cmd.cur_op = lcdtb_pkg::CUR_UP;
              if (lcdtb_pkg::LINE_COUNT > 1) begin
                cmd.ptr_op = lcdtb_pkg::PTR_ZERO;
                state_nxt  = ST_SCR_RD;
              end else begin
                cmd.ptr_op    = lcdtb_pkg::PTR_LAST_LINE;
                fill_sel_nxt  = lcdtb_pkg::FILL_CFG;
                ret_apply_nxt = 1'b1;
                state_nxt     = ST_FILL;
              end
            end else begin
              state_nxt = ST_APPLY;
            end
          end
          lcdtb_pkg::KIND_CLEAR: begin
            cmd.ptr_op    = lcdtb_pkg::PTR_ZERO;
            cmd.cur_op    = lcdtb_pkg::CUR_HOME;
            fill_sel_nxt  = lcdtb_pkg::FILL_SPACE;
            ret_apply_nxt = 1'b0;
            state_nxt     = ST_FILL;
          end
          lcdtb_pkg::KIND_REFRESH: begin
            cmd.ptr_op = lcdtb_pkg::PTR_ZERO;
            cmd.seq_op = lcdtb_pkg::SEQ_CLR;
            state_nxt  = ST_REF_HOME;
          end
          default: begin
            init_cnt_nxt = '0;
            state_nxt    = ST_INIT;
          end
        endcase
      end

      // scroll: copy each entry from one line below
      ST_SCR_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = lcdtb_pkg::RD_PTR_NEXT_LINE;
        state_nxt  = ST_SCR_WR;
      end

      ST_SCR_WR: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_sel = lcdtb_pkg::WR_COPY;
        cmd.ptr_op = lcdtb_pkg::PTR_INC;
        if (stat.ptr_scroll_end) begin
          fill_sel_nxt  = lcdtb_pkg::FILL_CFG;
          ret_apply_nxt = 1'b1;
          state_nxt     = ST_FILL;
        end else begin
          state_nxt = ST_SCR_RD;
        end
      end

      // fill from the pointer to the end of the store
      ST_FILL: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_sel = lcdtb_pkg::WR_FILL;
        if (stat.ptr_end) begin
          state_nxt = ret_apply_r ? ST_APPLY : ST_IDLE;
        end else begin
          cmd.ptr_op = lcdtb_pkg::PTR_INC;
        end
      end

      ST_APPLY: begin
        state_nxt = ST_IDLE;
        case (stat.code)
          lcdtb_pkg::CHAR_CR: cmd.cur_op = lcdtb_pkg::CUR_CR;
          lcdtb_pkg::CHAR_LF: cmd.cur_op = lcdtb_pkg::CUR_LF;
          lcdtb_pkg::CHAR_FF: begin
            cmd.cur_op    = lcdtb_pkg::CUR_HOME;
            cmd.ptr_op    = lcdtb_pkg::PTR_ZERO;
            fill_sel_nxt  = lcdtb_pkg::FILL_CFG;
            ret_apply_nxt = 1'b0;
            state_nxt     = ST_FILL;
          end
          default: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = lcdtb_pkg::WR_CHAR;
            cmd.cur_op = lcdtb_pkg::CUR_ADV;
          end
        endcase
      end

      ST_REF_HOME: begin
        cmd.emit  = lcdtb_pkg::EMIT_HOME;
        state_nxt = ST_REF_ROW;
      end

      ST_REF_ROW: begin
        cmd.emit  = lcdtb_pkg::EMIT_ROW;
        state_nxt = ST_REF_RD;
      end

      ST_REF_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_REF_DAT;
      end

      ST_REF_DAT: begin
        cmd.emit   = lcdtb_pkg::EMIT_DATA;
        cmd.ptr_op = lcdtb_pkg::PTR_INC;
        if (stat.seq_col_end) begin
          if (stat.seq_row_end) begin
            state_nxt = ST_REF_CUR;
          end else begin
            cmd.seq_op = lcdtb_pkg::SEQ_ROW_INC;
            state_nxt  = ST_REF_ROW;
          end
        end else begin
          cmd.seq_op = lcdtb_pkg::SEQ_COL_INC;
          state_nxt  = ST_REF_RD;
        end
      end

      ST_REF_CUR: begin
        cmd.emit      = lcdtb_pkg::EMIT_CURSOR;
        cmd.emit_last = 1'b1;
        state_nxt     = ST_IDLE;
      end

      ST_INIT: begin
        cmd.emit      = lcdtb_pkg::EMIT_INIT;
        cmd.emit_last = (init_cnt_r == lcdtb_pkg::INIT_LAST);
        init_cnt_nxt  = init_cnt_r + 2'd1;
        if (init_cnt_r == lcdtb_pkg::INIT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // reset sweeps the store to zero before the first request
      state_r     <= ST_FILL;
      fill_sel_r  <= lcdtb_pkg::FILL_ZERO;
      ret_apply_r <= 1'b0;
      init_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_sel_r  <= fill_sel_nxt;
      ret_apply_r <= ret_apply_nxt;
      init_cnt_r  <= init_cnt_nxt;
    end
  end

  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_DISP)
    else $error("accepted request not dispatched");

  // a last-marked write ends a refresh or init request and then the block is idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_last |=> state_r == ST_IDLE)
    else $error("final bus write not followed by idle");

  a_no_write_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REF_RD || state_r == ST_REF_DAT) |-> !cmd.mem_wr)
    else $error("store written during refresh");

endmodule

FILE: rtl/core/char_lcd_terminal_buffer_top.sv
// Character LCD text buffer with an HD44780-style command/data bus output.
// A request is taken when start is high and busy is low; busy stays high
// until the request is fully done. Bus writes appear on out_* for exactly
// one cycle each, flagged by out_strobe; the receiver cannot stall them and
// out_last marks the final write of a request. Work per request, with
// W = LINE_WIDTH, H = LINE_COUNT, S = W*H:
//   printable, CR, LF       move the cursor; a printable stores its byte
//   with scroll first       S-W copies up, fill last W (H = 1: no copies)
//   form feed               fill all S (plus the scroll above if it applies)
//   clear                   fill all S with spaces, cursor home
//   refresh                 home, per row its address and W data, cursor
//   init                    4 commands, one command per cycle
// Every scroll copy and every refresh byte is read from the frame store
// into a register before it is used, and fills write one entry per cycle.
// After reset the store is swept to zero with busy high.
// cfg_wr_data sets the form feed/scroll fill byte and may be written at
// any time the block is idle.
module char_lcd_terminal_buffer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_char_code,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output logic       out_strobe,
  output logic       out_is_data,
  output logic [7:0] out_bus_byte,
  output logic       out_last
);

  lcdtb_pkg::dp_cmd_t  cmd;
  lcdtb_pkg::dp_stat_t stat;

  // sequencer: decodes the request and walks the store
  lcdtb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // frame store, cursor, fill register and bus output register
  lcdtb_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_strobe   (out_strobe),
    .out_is_data  (out_is_data),
    .out_bus_byte (out_bus_byte),
    .out_last     (out_last)
  );

endmodule
